>>> rtl/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types and constants for the oversampled async bit decoder.
// ----------------------------------------------------------------------------
package obd_pkg;

	localparam int SMP_W      = 8;
	localparam int CNT_W      = 8;
	localparam int RUN_W      = 9;
	localparam int CARRY_W    = 3;
	localparam int K_W        = 7;
	localparam int NRES_W     = 3;

	localparam logic [CNT_W-1:0]         CNT_MAX   = 8'd255;
	localparam logic [CNT_W-1:0]         DATA_BITS = 8'd8;
	localparam logic [CNT_W-1:0]         STOP_POS  = 8'd10;
	localparam logic [CNT_W-1:0]         START_POS = 8'd11;
	localparam logic signed [RUN_W-1:0]  RUN_MAX   = 9'sd255;
	localparam logic [NRES_W-1:0]        MAX_RES   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_BITS,
		ST_END,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] idx;
		logic       done;
		logic [7:0] count;
	} res_t;

endpackage

>>> rtl/obd_res_buf.sv
// ----------------------------------------------------------------------------
// obd_res_buf
// Holds one pending result until the next one (or the end of the request)
// tells whether it is the last, then moves it to the output register.
// ----------------------------------------------------------------------------
module obd_res_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  obd_pkg::res_t push_res,
	input  logic          close,
	output logic          ok,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    decoded_byte,
	output logic [7:0]    byte_index,
	output logic          frame_done,
	output logic [7:0]    byte_count,
	output logic          last_result
);
	import obd_pkg::*;

	res_t pend_q;
	logic pend_v_q;
	res_t out_res_q;
	logic out_last_q;
	logic out_v_q;
	logic out_free;
	logic move;

	assign out_free = !out_v_q || out_ready;
	assign ok       = !pend_v_q || out_free;
	assign move     = pend_v_q && out_free && (push || close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push)
				pend_v_q <= 1'b1;
			else if (close)
				pend_v_q <= 1'b0;
			if (move)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			pend_q <= push_res;
		if (move) begin
			out_res_q  <= pend_q;
			out_last_q <= close;
		end
	end

	assign out_valid    = out_v_q;
	assign decoded_byte = out_res_q.data;
	assign byte_index   = out_res_q.idx;
	assign frame_done   = out_res_q.done;
	assign byte_count   = out_res_q.count;
	assign last_result  = out_last_q;

	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n) push |-> ok)
		else $error("result pushed while buffer full");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(push && close))
		else $error("push and close together");
	a_close: assert property (@(posedge clk) disable iff (!arst_n) close && ok |=> !pend_v_q)
		else $error("pending result left after close");
	a_push: assert property (@(posedge clk) disable iff (!arst_n) push |=> pend_v_q)
		else $error("pushed result not held");

endmodule

>>> rtl/oversampled_async_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// oversampled_async_bit_decoder_top
// Run-length decoder for a 4x oversampled async serial line.
// ----------------------------------------------------------------------------
// Each request carries eight line samples, oldest in bit 7, and is handled one
// sample per clock; a run end then emits its rounded bits one per clock, and
// the samples wait meanwhile. Emission holds while a result waits for room on
// the output side. A request occupies the block until it has closed, and the
// next one is taken only when the block is idle again. A zero at bit ten ends
// the request early, and a request while no frame is open is dropped in its
// accept cycle. in_ready is high only between requests. Up to five results
// come per request, the last marked by last_result; an output register lets
// the next request in while one waits.
module oversampled_async_bit_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] sample_byte,
	input  logic       frame_start,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] decoded_byte,
	output logic [7:0] byte_index,
	output logic       frame_done,
	output logic [7:0] byte_count,
	output logic       last_result
);
	import obd_pkg::*;

	state_t                    state_q, state_d;
	logic                      level_q, level_d;
	logic signed [RUN_W-1:0]   run_q, run_d;
	logic signed [CARRY_W-1:0] carry_q, carry_d;
	logic [CNT_W-1:0]          pos_q, pos_d;
	logic [7:0]                asm_q, asm_d;
	logic [CNT_W-1:0]          bytes_q, bytes_d;
	logic                      active_q, active_d;
	logic [SMP_W-1:0]          sh_q, sh_d;
	logic [2:0]                cnt_q, cnt_d;
	logic                      end_q, end_d;
	logic [K_W-1:0]            k_q, k_d;
	logic [NRES_W-1:0]         nres_q, nres_d;

	logic                      smp;
	logic [RUN_W:0]            run_p2;
	logic [K_W-1:0]            k_new;
	logic signed [CARRY_W-1:0] carry_new;
	logic signed [RUN_W-1:0]   run_glitch;
	logic [CNT_W-1:0]          pos_inc;
	logic [7:0]                asm_nx;
	logic                      bit_stop;
	logic                      bit_start;
	logic                      room;
	logic                      adv;
	logic                      push;
	logic                      close;
	logic                      ok;
	res_t                      push_res;
	res_t                      done_res;

	assign smp        = sh_q[SMP_W-1];
	assign run_p2     = {run_q[RUN_W-1], run_q} + 10'd2;
	assign k_new      = run_p2[K_W+1:2];
	assign carry_new  = $signed({1'b0, run_p2[1:0]}) - 3'sd2;
	assign run_glitch = {{(RUN_W-CARRY_W){carry_q[CARRY_W-1]}}, carry_q} + 9'sd1;
	assign pos_inc    = (pos_q == CNT_MAX) ? CNT_MAX : pos_q + 8'd1;
	assign asm_nx     = (pos_q < DATA_BITS) ? {level_q, asm_q[7:1]} : asm_q;
	assign bit_stop   = (pos_inc == STOP_POS) && !level_q;
	assign bit_start  = (pos_inc >= START_POS) && !level_q;
	assign room       = nres_q < MAX_RES;
	assign done_res   = '{data: 8'd0, idx: 8'd0, done: 1'b1, count: bytes_q};

	always_comb begin
		state_d  = state_q;
		level_d  = level_q;
		run_d    = run_q;
		carry_d  = carry_q;
		pos_d    = pos_q;
		asm_d    = asm_q;
		bytes_d  = bytes_q;
		active_d = active_q;
		sh_d     = sh_q;
		cnt_d    = cnt_q;
		end_d    = end_q;
		k_d      = k_q;
		nres_d   = nres_q;
		in_ready = 1'b0;
		adv      = 1'b0;
		push     = 1'b0;
		close    = 1'b0;
		push_res = done_res;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (frame_start) begin
						level_d  = sample_byte[7];
						run_d    = '0;
						carry_d  = '0;
						pos_d    = '0;
						asm_d    = '0;
						bytes_d  = '0;
						active_d = 1'b1;
					end
					if (frame_start || active_q) begin
						sh_d    = sample_byte;
						cnt_d   = '0;
						end_d   = frame_end;
						nres_d  = '0;
						state_d = ST_SAMPLE;
					end
				end
			end
			ST_SAMPLE: begin
				if (smp == level_q) begin
					if (run_q != RUN_MAX)
						run_d = run_q + 9'sd1;
					adv = 1'b1;
				end else if (run_q == 9'sd1) begin
					level_d = smp;
					run_d   = run_glitch;
					adv     = 1'b1;
				end else begin
					carry_d = carry_new;
					if (k_new == '0) begin
						level_d = smp;
						run_d   = 9'sd1;
						adv     = 1'b1;
					end else begin
						k_d     = k_new;
						state_d = ST_BITS;
					end
				end
			end
			ST_BITS: begin
				if (!((bit_stop || bit_start) && room && !ok)) begin
					asm_d = asm_nx;
					if (bit_stop) begin
						pos_d    = pos_inc;
						push     = room;
						nres_d   = room ? nres_q + 3'd1 : nres_q;
						active_d = 1'b0;
						state_d  = ST_CLOSE;
					end else begin
						if (bit_start) begin
							pos_d    = '0;
							push     = room;
							push_res = '{data: asm_nx, idx: bytes_q, done: 1'b0, count: 8'd0};
							nres_d   = room ? nres_q + 3'd1 : nres_q;
							bytes_d  = (bytes_q == CNT_MAX) ? CNT_MAX : bytes_q + 8'd1;
						end else begin
							pos_d = pos_inc;
						end
						k_d = k_q - 7'd1;
						if (k_q == 7'd1) begin
							level_d = smp;
							run_d   = 9'sd1;
							adv     = 1'b1;
						end
					end
				end
			end
			ST_END: begin
				if (end_q) begin
					if (!(room && !ok)) begin
						push     = room;
						nres_d   = room ? nres_q + 3'd1 : nres_q;
						active_d = 1'b0;
						state_d  = ST_CLOSE;
					end
				end else begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				close = ok;
				if (ok)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (adv) begin
			sh_d    = {sh_q[SMP_W-2:0], 1'b0};
			cnt_d   = cnt_q + 3'd1;
			state_d = (cnt_q == 3'd7) ? ST_END : ST_SAMPLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			level_q  <= 1'b0;
			run_q    <= '0;
			carry_q  <= '0;
			pos_q    <= '0;
			asm_q    <= '0;
			bytes_q  <= '0;
			active_q <= 1'b0;
			cnt_q    <= '0;
			nres_q   <= '0;
		end else begin
			state_q  <= state_d;
			level_q  <= level_d;
			run_q    <= run_d;
			carry_q  <= carry_d;
			pos_q    <= pos_d;
			asm_q    <= asm_d;
			bytes_q  <= bytes_d;
			active_q <= active_d;
			cnt_q    <= cnt_d;
			nres_q   <= nres_d;
		end
	end

	always_ff @(posedge clk) begin
		sh_q  <= sh_d;
		end_q <= end_d;
		k_q   <= k_d;
	end

	obd_res_buf u_res_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_res     (push_res),
		.close        (close),
		.ok           (ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.decoded_byte (decoded_byte),
		.byte_index   (byte_index),
		.frame_done   (frame_done),
		.byte_count   (byte_count),
		.last_result  (last_result)
	);

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the oversampled async bit decoder. Requests carry
// line samples built from serial characters, with jitter, glitches and
// noise. A local decoder predicts each result, and every result taken from
// the output side is checked in order against that prediction. Both sides
// idle at random, and a long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module testbench;
	import obd_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] idx;
		logic       done;
		logic [7:0] count;
		logic       last;
	} decoded_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] sample_byte = '0;
	logic       frame_start = 1'b0;
	logic       frame_end   = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] decoded_byte;
	logic [7:0] byte_index;
	logic       frame_done;
	logic [7:0] byte_count;
	logic       last_result;

	oversampled_async_bit_decoder_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_byte (sample_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.decoded_byte(decoded_byte),
		.byte_index  (byte_index),
		.frame_done  (frame_done),
		.byte_count  (byte_count),
		.last_result (last_result)
	);

	always #2 clk = ~clk;

	// decoder state as seen by the predictor
	logic              line_lvl;
	logic signed [8:0] run_len;
	logic signed [2:0] carry;
	logic [7:0]        bit_pos;
	logic [7:0]        shift_byte;
	logic [7:0]        byte_cnt;
	logic              active;

	decoded_t decoded_q[$];
	bit       frame_bits[$];
	bit       line_samples[$];

	int  send_gap_pct   = 0;
	int  recv_gap_pct   = 0;
	bit  hold_req       = 1'b0;
	logic holding       = 1'b0;
	int  requests_sent  = 0;
	int  frame_requests = 0;
	int  frames_sent    = 0;
	int  bytes_checked  = 0;
	int  frames_closed  = 0;
	int  mismatch_count = 0;

	function automatic void clear_decoder();
		line_lvl   = 1'b0;
		run_len    = '0;
		carry      = '0;
		bit_pos    = '0;
		shift_byte = '0;
		byte_cnt   = '0;
		active     = 1'b0;
	endfunction

	function automatic void decode_samples(input logic [7:0] smp_byte, input logic start,
		input logic fin);
		decoded_t res[$];
		logic smp;
		int   k;
		int   i;
		int   j;
		if (start) begin
			clear_decoder();
			active   = 1'b1;
			line_lvl = smp_byte[7];
		end
		if (!active)
			return;
		for (j = 0; j < 8 && active; j++) begin
			smp = smp_byte[7-j];
			if (smp == line_lvl) begin
				if (run_len < RUN_MAX)
					run_len = run_len + 9'sd1;
			end else if (run_len == 9'sd1) begin
				// glitch: one-sample run flips the level back
				line_lvl = smp;
				run_len  = carry + 9'sd1;
			end else begin
				k     = (int'(run_len) + 2) / 4;
				carry = 3'(int'(run_len) - 4 * k);
				for (i = 0; i < k; i++) begin
					if (bit_pos < DATA_BITS)
						shift_byte = {line_lvl, shift_byte[7:1]};
					if (bit_pos < CNT_MAX)
						bit_pos = bit_pos + 8'd1;
					if (bit_pos == STOP_POS && !line_lvl) begin
						if (res.size() < int'(MAX_RES))
							res.push_back('{8'd0, 8'd0, 1'b1, byte_cnt, 1'b0});
						active = 1'b0;
						break;
					end
					if (bit_pos >= START_POS && !line_lvl) begin
						bit_pos = '0;
						if (res.size() < int'(MAX_RES))
							res.push_back('{shift_byte, byte_cnt, 1'b0, 8'd0, 1'b0});
						if (byte_cnt < CNT_MAX)
							byte_cnt = byte_cnt + 8'd1;
					end
				end
				if (!active)
					break;
				line_lvl = smp;
				run_len  = 9'sd1;
			end
		end
		if (active && fin) begin
			if (res.size() < int'(MAX_RES))
				res.push_back('{8'd0, 8'd0, 1'b1, byte_cnt, 1'b0});
			active = 1'b0;
		end
		if (res.size() > 0)
			res[res.size()-1].last = 1'b1;
		foreach (res[i])
			decoded_q.push_back(res[i]);
	endfunction

	task automatic report_error(input string what, input decoded_t want, input decoded_t got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRORS) begin
			$display("%0t %s: expected data %02h idx %0d done %0b count %0d last %0b,",
				$time, what, want.data, want.idx, want.done, want.count, want.last);
			$display("    got data %02h idx %0d done %0b count %0d last %0b",
				got.data, got.idx, got.done, got.count, got.last);
		end
	endtask

	// result checker and receiver pacing
	always @(posedge clk) begin
		decoded_t want;
		decoded_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {decoded_byte, byte_index, frame_done, byte_count, last_result};
			if (got.done)
				frames_closed++;
			else
				bytes_checked++;
			if (decoded_q.size() == 0) begin
				report_error("unexpected result", '0, got);
			end else begin
				want = decoded_q.pop_front();
				if (got !== want)
					report_error("result mismatch", want, got);
			end
		end
		out_ready <= holding ? 1'b0 : ($urandom_range(99) >= recv_gap_pct);
	end

	// long receiver hold-off
	always begin
		wait (hold_req);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
		hold_req = 1'b0;
	end

	task automatic send_request(input logic [7:0] smp, input logic start, input logic fin);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_byte <= smp;
		frame_start <= start;
		frame_end   <= fin;
		do @(posedge clk); while (!in_ready);
		decode_samples(smp, start, fin);
		requests_sent++;
	endtask

	function automatic void add_run(input bit lvl, input int nbits, input bit dense);
		int n;
		int glitch_at;
		int i;
		n = dense ? 4 * nbits - 2 : 4 * nbits - 1 + $urandom_range(2);
		glitch_at = -1;
		if (!dense && n >= 6 && $urandom_range(15) == 0)
			glitch_at = $urandom_range(n - 3, 2);
		for (i = 0; i < n; i++)
			line_samples.push_back((i == glitch_at) ? !lvl : lvl);
	endfunction

	function automatic void bits_to_samples(input bit dense);
		int i;
		int c;
		i = 0;
		while (i < frame_bits.size()) begin
			c = 1;
			while (i + c < frame_bits.size() && frame_bits[i+c] == frame_bits[i])
				c++;
			add_run(frame_bits[i], c, dense);
			i += c;
		end
		frame_bits.delete();
	endfunction

	function automatic void queue_char(input logic [7:0] data, input bit lead_start,
		input int stops);
		int i;
		if (lead_start)
			frame_bits.push_back(1'b0);
		for (i = 0; i < 8; i++)
			frame_bits.push_back(data[i]);
		repeat (stops) frame_bits.push_back(1'b1);
	endfunction

	function automatic void queue_random_frame();
		int nchars;
		int c;
		nchars = $urandom_range(4);
		for (c = 0; c < nchars; c++)
			queue_char(8'($urandom_range(255)), c > 0, 2 + $urandom_range(2));
		if ($urandom_range(1)) begin
			// ends with a zero at bit ten
			queue_char(8'($urandom_range(255)), nchars > 0, 1);
			frame_bits.push_back(1'b0);
			frame_bits.push_back(1'b1);
			frame_bits.push_back(1'b1);
		end else begin
			queue_char(8'($urandom_range(255)), nchars > 0, 2);
		end
	endfunction

	task automatic send_samples(input bit close);
		int nbytes;
		int i;
		int j;
		logic [7:0] b;
		while (line_samples.size() == 0 || line_samples.size() % 8 != 0)
			line_samples.push_back(1'b1);
		nbytes = line_samples.size() / 8;
		for (i = 0; i < nbytes; i++) begin
			for (j = 0; j < 8; j++)
				b[7-j] = line_samples[8*i+j];
			send_request(b, i == 0, close && i == nbytes - 1);
			frame_requests++;
		end
		line_samples.delete();
		frames_sent++;
	endtask

	task automatic test_idle_and_edges();
		send_request(8'h55, 1'b0, 1'b0);
		send_request(8'hAA, 1'b0, 1'b1);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
		// glitch leaving a negative run
		send_request(8'hD0, 1'b1, 1'b0);
		send_request(8'h3C, 1'b0, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_known_frame();
		queue_char(8'h00, 1'b0, 2);
		queue_char(8'hFF, 1'b1, 3);
		queue_char(8'hA5, 1'b1, 1);
		frame_bits.push_back(1'b0);
		frame_bits.push_back(1'b1);
		frame_bits.push_back(1'b1);
		bits_to_samples(1'b0);
		send_samples(1'b1);
	endtask

	task automatic test_long_runs();
		int burst;
		send_request(8'hFF, 1'b1, 1'b0);
		for (burst = 0; burst < 4; burst++) begin
			repeat (32) send_request(8'hFF, 1'b0, 1'b0);
			send_request(8'hFE, 1'b0, 1'b0);
		end
		send_request(8'h00, 1'b0, 1'b0);
		send_request(8'h0F, 1'b0, 1'b0);
		send_request(8'hFF, 1'b0, 1'b1);
	endtask

	task automatic test_many_bytes();
		int c;
		for (c = 0; c < 12; c++)
			queue_char(8'($urandom_range(255)), c > 0, 2);
		bits_to_samples(1'b1);
		send_samples(1'b1);
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int goal,
		input bit squeeze);
		int first;
		int pick;
		int cut;
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
		if (squeeze)
			hold_req = 1'b1;
		first = frame_requests;
		while (frame_requests - first < goal) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				send_request(8'($urandom_range(255)), $urandom_range(7) == 0,
					$urandom_range(3) == 0);
			end else begin
				queue_random_frame();
				bits_to_samples($urandom_range(3) == 0);
				if (pick < 27) begin
					// truncated frame, maybe never closed
					cut = $urandom_range(line_samples.size() - 1, 1);
					while (line_samples.size() > cut)
						void'(line_samples.pop_back());
					send_samples(1'($urandom_range(1)));
				end else begin
					send_samples(1'b1);
				end
			end
		end
	endtask

	task automatic finish_requests();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		clear_decoder();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_edges();
		test_known_frame();
		test_long_runs();
		test_many_bytes();
		test_random_phase(10, 74, 70, 1'b1);
		test_random_phase(74, 10, 70, 1'b0);
		test_random_phase(0, 0, 70, 1'b1);
		finish_requests();
		$display("Sent %0d requests in %0d built frames plus noise and edge cases.",
			requests_sent, frames_sent);
		$display("Checked %0d decoded bytes and %0d frame ends, %0d mismatches.",
			bytes_checked, frames_closed, mismatch_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d results still expected.", decoded_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
